// ===== hdl/mft_pkg.sv =====
// Shared widths, sizes and status codes for the Mertens function table.
// No dependencies; every other file of the block but mft_ram imports this package.
`default_nettype none

package mft_pkg;

	// Table size and derived address width
	localparam int TABLE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Field widths
	localparam int IDX_W = 17;
	localparam int VAL_W = 16;
	localparam int STS_W = 2;

	// Running sum of up to n/3 signed table values, with headroom
	localparam int ACC_W = 34;

	// Reset value of the last-index register
	localparam logic [IDX_W-1:0] LAST_INDEX_RST = IDX_W'(65536);

	// Result status codes
	localparam logic [STS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STS_W-1:0] STAT_OVF  = 2'd1;
	localparam logic [STS_W-1:0] STAT_PAST = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/mft_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// Standalone; no package needed.
`default_nettype none

module mft_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/mft_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for n / i.
// Depends on mft_pkg for the operand width.
`default_nettype none

module mft_div
	import mft_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [IDX_W-1:0] dividend,
	input  wire logic [IDX_W-1:0] divisor,
	output logic                  done,
	output logic      [IDX_W-1:0] quotient
);

	localparam int CNT_W = $clog2(IDX_W + 1);

	logic [IDX_W-1:0] quo_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [IDX_W:0]   rem_sh;
	logic [IDX_W+1:0] diff;
	logic             fits;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh = {rem_q, quo_q[IDX_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
		fits   = ~diff[IDX_W+1];
	end

	// Iterate over all quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			cnt_q  <= CNT_W'(IDX_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q  <= {quo_q[IDX_W-2:0], fits};
			rem_q  <= fits ? diff[IDX_W-1:0] : rem_sh[IDX_W-1:0];
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/mertens_function_table.sv =====
// Top level of the Mertens function table: sequencer, accumulator, output register.
// Depends on mft_pkg, mft_div and mft_ram.
//
// Each accepted item yields one result: the next M(n), or M(1) = 1 when restart is
// set. M(n) is built from earlier table values as 1 - sum M(n/i) over i = 2..n/3
// - (n+1)/2, with one serial division and one table read per term. Each term passes
// through the check, divide and read states in turn; items for n below 6 have no terms
// and go from the check state straight to the end state, and items for an index past
// last_index or after an overflow skip the term loop and go straight to output. The
// block accepts one item at a time; a finished result waits in the output register
// while the next item is taken. After an overflow every item reports status 1 until
// a restart; past the last index every item reports status 2 until a restart or a
// larger last_index. last_index may be written whenever cfg_ready is high, which is
// always.
`default_nettype none

module mertens_function_table
	import mft_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] last_index,
	// input items
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             restart,
	// results
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [IDX_W-1:0] index_n,
	output logic      [VAL_W-1:0] mertens_value,
	output logic      [STS_W-1:0] status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_DIV,
		S_RD,
		S_END,
		S_OUT
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] next_q;
	logic             ovf_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W:0]   i3_q;
	logic [ACC_W-1:0] acc_q;
	logic [VAL_W-1:0] res_val_q;
	logic [STS_W-1:0] res_sts_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] index_q;
	logic [VAL_W-1:0] value_q;
	logic [STS_W-1:0] status_q;

	logic             in_xfer;
	logic [IDX_W-1:0] n_in;
	logic             ovf_in;
	logic             past_in;
	logic             more_terms;
	logic             div_start;
	logic             div_done;
	logic [IDX_W-1:0] div_quo;
	logic [IDX_W-1:0] quo_m1;
	logic [IDX_W-1:0] n_m1;
	logic [VAL_W-1:0] rd_data;
	logic [IDX_W:0]   half_n;
	logic [ACC_W-1:0] t_w;
	logic             t_fits;
	logic             ram_we;
	logic             out_load;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;

	// Item entry: restart returns to n = 1 and clears the overflow flag
	always_comb begin
		n_in    = restart ? IDX_W'(1) : next_q;
		ovf_in  = restart ? 1'b0 : ovf_q;
		past_in = (n_in > last_q) || (32'(n_in) > 32'(TABLE_DEPTH)) ||
		          (n_in == '0);
	end

	// Term loop runs while 3*i <= n
	assign more_terms = (i3_q <= {1'b0, n_q});
	assign div_start  = (state_q == S_CHK) && more_terms;

	// Table address of M(n/i) and of M(n)
	assign quo_m1 = div_quo - IDX_W'(1);
	assign n_m1   = n_q - IDX_W'(1);

	// Final value: 1 - sum - (n+1)/2, and its 16-bit range check; M(1) has no halving term
	always_comb begin
		half_n = (n_q == IDX_W'(1)) ? '0 : (({1'b0, n_q} + (IDX_W+1)'(1)) >> 1);
		t_w    = ACC_W'(1) - acc_q - ACC_W'(half_n);
		t_fits = (&t_w[ACC_W-1:VAL_W-1]) || !(|t_w[ACC_W-1:VAL_W-1]);
	end

	assign ram_we   = (state_q == S_END) && t_fits;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	mft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (i_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	mft_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (n_m1[ADDR_W-1:0]),
		.wdata (t_w[VAL_W-1:0]),
		.raddr (quo_m1[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// Sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= LAST_INDEX_RST;
			next_q      <= IDX_W'(1);
			ovf_q       <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			i3_q        <= '0;
			acc_q       <= '0;
			res_val_q   <= '0;
			res_sts_q   <= STAT_OK;
			out_valid_q <= 1'b0;
			index_q     <= '0;
			value_q     <= '0;
			status_q    <= STAT_OK;
		end else begin
			// capture the configuration write of last_index
			if (cfg_valid && cfg_ready) begin
				last_q <= last_index;
			end

			// load a new result, or drop the result once transferred
			if (out_load) begin
				out_valid_q <= 1'b1;
				index_q     <= n_q;
				value_q     <= res_val_q;
				status_q    <= res_sts_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						n_q   <= n_in;
						ovf_q <= ovf_in;
						acc_q <= '0;
						i_q   <= IDX_W'(2);
						i3_q  <= (IDX_W+1)'(6);
						if (restart) begin
							next_q <= IDX_W'(1);
						end
						if (ovf_in) begin
							res_val_q <= '0;
							res_sts_q <= STAT_OVF;
							state_q   <= S_OUT;
						end else if (past_in) begin
							res_val_q <= '0;
							res_sts_q <= STAT_PAST;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					state_q <= more_terms ? S_DIV : S_END;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// add M(n/i) and advance i
					acc_q   <= acc_q + {{(ACC_W-VAL_W){rd_data[VAL_W-1]}}, rd_data};
					i_q     <= i_q + IDX_W'(1);
					i3_q    <= i3_q + (IDX_W+1)'(3);
					state_q <= S_CHK;
				end
				S_END: begin
					if (t_fits) begin
						next_q    <= n_q + IDX_W'(1);
						res_val_q <= t_w[VAL_W-1:0];
						res_sts_q <= STAT_OK;
					end else begin
						ovf_q     <= 1'b1;
						res_val_q <= '0;
						res_sts_q <= STAT_OVF;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign index_n       = index_q;
	assign mertens_value = value_q;
	assign status        = status_q;

endmodule

`default_nettype wire

// ===== hdl/mft_chk.sv =====
// Port-level checks for the Mertens function table, bound to the top level.
// Depends on mft_pkg for widths and status codes.
`default_nettype none

module mft_chk
	import mft_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [IDX_W-1:0] index_n,
	input wire logic [VAL_W-1:0] mertens_value,
	input wire logic [STS_W-1:0] status
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(index_n) &&
		$stable(mertens_value) && $stable(status))
		else $error("result changed while stalled");

	// Error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> mertens_value == '0)
		else $error("nonzero value with error status");

	// M(1) is one
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_OK && index_n == IDX_W'(1) |->
		mertens_value == VAL_W'(1))
		else $error("M(1) is not one");

	// One item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

endmodule

bind mertens_function_table mft_chk u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the Mertens function table block.
// Depends on mft_pkg and mertens_function_table; runs standalone with no inputs.
`timescale 1ns / 100ps

module tb;
	import mft_pkg::*;

	localparam int          HALF_PERIOD = 6;
	localparam int          RESET_CYCLES = 7;
	localparam int          HOLD_CYCLES = 2000;
	localparam int          TAIL_CYCLES = 50;
	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          PHASE_ITEMS = 26;
	localparam bit          ADVANCE = 1'b0;
	localparam bit          RESTART = 1'b1;
	localparam logic [IDX_W-1:0] MAX_LAST = IDX_W'(65536);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		logic [STS_W-1:0] sts;
	} mertens_res_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] last_index = LAST_INDEX_RST;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             restart = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] index_n;
	logic [VAL_W-1:0] mertens_value;
	logic [STS_W-1:0] status;

	// Stimulus and expectation stores
	bit           item_q[$];
	mertens_res_t mertens_exp_q[$];

	// Mirror of the block state for prediction
	shortint          m_tab[TABLE_DEPTH];
	logic [IDX_W-1:0] pred_next_n = IDX_W'(1);
	bit               pred_ovf = 1'b0;
	logic [IDX_W-1:0] pred_last = LAST_INDEX_RST;

	int  snd_idle_pct = 0;
	int  rcv_idle_pct = 0;
	bit  hold_go = 1'b0;
	int  hold_left = 0;
	int  err_cnt = 0;
	int  cycle_cnt = 0;

	mertens_function_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.last_index   (last_index),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.index_n      (index_n),
		.mertens_value(mertens_value),
		.status       (status)
	);

	always #HALF_PERIOD clk = ~clk;

	// Compute the result of one item and advance the mirrored state
	function automatic mertens_res_t next_mertens(bit rst);
		mertens_res_t r;
		int unsigned  n;
		int unsigned  lim;
		longint       acc;
		if (rst) begin
			pred_next_n = IDX_W'(1);
			pred_ovf = 1'b0;
		end
		n = pred_next_n;
		r.idx = IDX_W'(n);
		r.val = '0;
		if (pred_ovf) begin
			r.sts = STAT_OVF;
			return r;
		end
		lim = pred_last;
		if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
		if (n > lim || n == 0) begin
			r.sts = STAT_PAST;
			return r;
		end
		if (n == 1) begin
			acc = 1;
		end else begin
			// terms with n/i of 1 or 2 collapse into (n+1)/2
			acc = 0;
			for (int unsigned i = 2; i <= n / 3; i++) acc += m_tab[n / i - 1];
			acc += (n + 1) / 2;
			acc = 1 - acc;
		end
		if (acc > 32767 || acc < -32768) begin
			pred_ovf = 1'b1;
			r.sts = STAT_OVF;
			return r;
		end
		m_tab[n - 1] = shortint'(acc);
		pred_next_n = IDX_W'(n + 1);
		r.val = VAL_W'(acc);
		r.sts = STAT_OK;
		return r;
	endfunction

	// Driver: offer queued items, hold each until its transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				mertens_exp_q.push_back(next_mertens(item_q.pop_front()));
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (item_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				in_valid <= 1'b1;
				restart <= item_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin : mon
		mertens_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (mertens_exp_q.size() == 0) begin
					$error("unexpected result: index_n %0d value %0d status %0d",
						index_n, $signed(mertens_value), status);
					err_cnt++;
				end else begin
					want = mertens_exp_q.pop_front();
					if (index_n !== want.idx) begin
						$error("index_n: expected %0d, got %0d", want.idx, index_n);
						err_cnt++;
					end
					if (mertens_value !== want.val) begin
						$error("mertens_value: expected %0d, got %0d",
							$signed(want.val), $signed(mertens_value));
						err_cnt++;
					end
					if (status !== want.sts) begin
						$error("status: expected %0d, got %0d", want.sts, status);
						err_cnt++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Write last_index through the config channel and mirror it
	task automatic write_last(logic [IDX_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		last_index <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred_last = v;
	endtask

	// Wait until every item is sent and every result has come back
	task automatic wait_drained();
		do @(negedge clk); while (item_q.size() != 0 || in_valid || mertens_exp_q.size() != 0);
	endtask

	task automatic push_items(bit r, int count);
		for (int k = 0; k < count; k++) item_q.push_back(r);
	endtask

	// Mostly advancing sequences with an occasional restart
	task automatic push_random(int count);
		for (int k = 0; k < count; k++) item_q.push_back($urandom_range(11) == 0);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// sender mostly busy, receiver mostly stalled
		snd_idle_pct = 16;
		rcv_idle_pct = 82;

		// last index of one: first value, then past the end, restart
		write_last(IDX_W'(1));
		@(negedge clk);
		push_items(ADVANCE, 3);
		push_items(RESTART, 1);
		push_items(ADVANCE, 1);
		wait_drained();

		// raise the limit: continue to n = 12, then one past it
		write_last(IDX_W'(12));
		@(negedge clk);
		push_items(ADVANCE, 12);
		wait_drained();

		// all low bits set: continue, restart, advance
		write_last(IDX_W'(65535));
		@(negedge clk);
		push_items(ADVANCE, 3);
		push_items(RESTART, 1);
		push_items(ADVANCE, 2);
		wait_drained();

		write_last(IDX_W'($urandom_range(160, 40)));
		@(negedge clk);
		push_random(PHASE_ITEMS);
		wait_drained();

		// sender mostly idle, receiver mostly ready; tight limit hits past-end often
		snd_idle_pct = 82;
		rcv_idle_pct = 16;
		write_last(IDX_W'($urandom_range(40, 1)));
		@(negedge clk);
		push_random(PHASE_ITEMS);
		wait_drained();

		// no idling, with one long receiver hold-off to back up the input
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_last(MAX_LAST);
		@(negedge clk);
		push_random(PHASE_ITEMS);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
